/* hdl/bbd_pkg.sv */
// ----------------------------------------------------------------------------
// bbd_pkg - shared types and helpers for the bilinear Bayer demosaic
// Word types for both channels, the command word between front and back end,
// register codes and small arithmetic helpers.
// ----------------------------------------------------------------------------
package bbd_pkg;

  localparam int MAX_WIDTH   = 4096;
  localparam int SAMPLE_BITS = 16;
  localparam int COL_BITS    = 12;
  localparam int DIM_BITS    = 13;
  localparam int POS_BITS    = 25;
  localparam int SUM_BITS    = 19;
  localparam int CNT_BITS    = 3;
  localparam int ADDR_BITS   = $clog2(MAX_WIDTH);

  // register indexes on the configuration port
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_CFA_PATTERN  = 2'd2;

  localparam logic [DIM_BITS-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [DIM_BITS-1:0] HEIGHT_RESET = 13'd480;
  localparam logic [DIM_BITS-1:0] DIM_MIN      = 13'd2;
  localparam logic [DIM_BITS-1:0] DIM_MAX      = 13'd4096;

  // input word kinds
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  // colour site codes
  localparam logic [1:0] SITE_RED      = 2'd0;
  localparam logic [1:0] SITE_GREEN_R  = 2'd1;
  localparam logic [1:0] SITE_GREEN_B  = 2'd2;
  localparam logic [1:0] SITE_BLUE     = 2'd3;

  // ceil(2^19 / 3): exact quotient by three for sums below 2^19
  localparam logic [17:0] RECIP3       = 18'd174763;
  localparam int          RECIP3_SHIFT = 19;

  typedef struct packed {
    logic                   req_type;
    logic [SAMPLE_BITS-1:0] raw_sample;
  } in_word_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] blue_value;
    logic [SAMPLE_BITS-1:0] green_value;
    logic [SAMPLE_BITS-1:0] red_value;
    logic [COL_BITS-1:0]    out_column;
    logic [COL_BITS-1:0]    out_row;
    logic                   frame_end;
  } out_word_t;

  // one decoded item for the back end
  typedef struct packed {
    logic                   wr;
    logic                   emit;
    logic [ADDR_BITS-1:0]   addr;
    logic [SAMPLE_BITS-1:0] sample;
    logic [COL_BITS-1:0]    x;
    logic [COL_BITS-1:0]    y;
    logic                   last;
    logic                   has_l;
    logic                   has_r;
    logic                   has_u;
    logic                   has_d;
    logic [1:0]             site;
  } cmd_t;

  // raster advance with wrap at width and height
  function automatic logic [2*COL_BITS-1:0] advance_pos(
    input logic [COL_BITS-1:0] col,
    input logic [COL_BITS-1:0] row,
    input logic [DIM_BITS-1:0] w,
    input logic [DIM_BITS-1:0] h
  );
    logic [DIM_BITS-1:0] c;
    logic [DIM_BITS-1:0] r;
    c = {1'b0, col} + 13'd1;
    r = {1'b0, row};
    if (c >= w) begin
      c = '0;
      r = r + 13'd1;
    end
    if (r >= h) r = '0;
    return {r[COL_BITS-1:0], c[COL_BITS-1:0]};
  endfunction

  // truncating divide by a neighbor count of one to four
  function automatic logic [SAMPLE_BITS-1:0] div_count(
    input logic [SUM_BITS-1:0] num,
    input logic [CNT_BITS-1:0] cnt
  );
    logic [SUM_BITS+17:0] prod;
    logic [SAMPLE_BITS-1:0] q;
    prod = (SUM_BITS+18)'(num) * (SUM_BITS+18)'(RECIP3);
    unique case (cnt)
      3'd1:    q = num[SAMPLE_BITS-1:0];
      3'd2:    q = num[SAMPLE_BITS:1];
      3'd3:    q = prod[RECIP3_SHIFT+SAMPLE_BITS-1:RECIP3_SHIFT];
      3'd4:    q = num[SAMPLE_BITS+1:2];
      default: q = '0;
    endcase
    return q;
  endfunction

endpackage

/* hdl/bbd_ram.sv */
// ----------------------------------------------------------------------------
// bbd_ram - generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bbd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hdl/bbd_fifo.sv */
// ----------------------------------------------------------------------------
// bbd_fifo - command queue between front and back end
// Four-entry register queue of decoded commands.
// ----------------------------------------------------------------------------
module bbd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  bbd_pkg::cmd_t push_cmd,
  input  logic          pop,
  output bbd_pkg::cmd_t head_cmd,
  output logic          full,
  output logic          empty
);
  import bbd_pkg::*;

  cmd_t       slot_r [4];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [2:0] count_r, count_nxt;

  assign full     = (count_r == 3'd4);
  assign empty    = (count_r == 3'd0);
  assign head_cmd = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + 2'(push);
    rd_ptr_nxt = rd_ptr_r + 2'(pop);
    count_nxt  = count_r + 3'(push) - 3'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_cmd;
  end

endmodule

/* hdl/bbd_front.sv */
// ----------------------------------------------------------------------------
// bbd_front - input side of the demosaic
// Take words, track raster positions, decide emission and queue commands.
// ----------------------------------------------------------------------------
module bbd_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  bbd_pkg::in_word_t             in_data,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [bbd_pkg::DIM_BITS-1:0]  cfg_data,
  input  logic                          q_full,
  output logic                          q_push,
  output bbd_pkg::cmd_t                 q_cmd
);
  import bbd_pkg::*;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_CALC = 3'b010,
    F_DEC  = 3'b100
  } fstate_t;

  fstate_t             state_r, state_nxt;
  logic [DIM_BITS-1:0] frame_width_r, frame_height_r;
  logic [1:0]          cfa_r;
  logic [COL_BITS-1:0] in_col_r, in_row_r, em_col_r, em_row_r;
  logic [COL_BITS-1:0] in_col_nxt, in_row_nxt, em_col_nxt, em_row_nxt;
  in_word_t            item_r;
  logic [POS_BITS-1:0] pa_r, pb_r, total_r;

  logic [DIM_BITS-1:0]   w, h;
  logic [POS_BITS:0]     pend;
  logic [2*COL_BITS-1:0] in_adv, em_adv;
  logic [DIM_BITS-1:0]   vcol;
  logic [1:0]            code;
  logic                  bx, by;
  logic                  accept;

  always_comb begin
    w = frame_width_r;
    if (w < DIM_MIN) w = DIM_MIN;
    if (w > DIM_MAX) w = DIM_MAX;
    h = frame_height_r;
    if (h < DIM_MIN) h = DIM_MIN;
    if (h > DIM_MAX) h = DIM_MAX;
  end

  assign in_ready = (state_r == F_IDLE) && !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    if (pa_r >= pb_r) pend = (POS_BITS+1)'(pa_r) - (POS_BITS+1)'(pb_r);
    else pend = (POS_BITS+1)'(pa_r) + (POS_BITS+1)'(total_r) - (POS_BITS+1)'(pb_r);
  end

  assign in_adv = advance_pos(in_col_r, in_row_r, w, h);
  assign em_adv = advance_pos(em_col_r, em_row_r, w, h);

  // site phase, odd height: 0 RGGB, 1 GRBG, 2 GBRG, 3 BGGR; even height swaps 0/2 and 1/3
  always_comb begin
    unique case (cfa_r)
      2'd0:    code = 2'd2;
      2'd1:    code = 2'd3;
      2'd2:    code = 2'd0;
      default: code = 2'd1;
    endcase
    bx = code[0];
    by = code[1] ^ h[0];
  end

  always_comb begin
    vcol = {1'b0, em_col_r} + 13'd1;
    if (vcol >= w) vcol = '0;
  end

  always_comb begin
    state_nxt  = state_r;
    in_col_nxt = in_col_r;
    in_row_nxt = in_row_r;
    em_col_nxt = em_col_r;
    em_row_nxt = em_row_r;
    q_push     = 1'b0;

    q_cmd        = '0;
    q_cmd.x      = em_col_r;
    q_cmd.y      = em_row_r;
    q_cmd.last   = ({1'b0, em_col_r} + 13'd1 == w) && ({1'b0, em_row_r} + 13'd1 == h);
    q_cmd.has_l  = (em_col_r != '0);
    q_cmd.has_r  = ({1'b0, em_col_r} + 13'd1 < w);
    q_cmd.has_u  = (em_row_r != '0);
    q_cmd.has_d  = ({1'b0, em_row_r} + 13'd1 < h);
    q_cmd.site   = {em_row_r[0] ^ by, em_col_r[0] ^ bx};

    unique case (state_r)
      F_IDLE: if (accept) state_nxt = F_CALC;
      F_CALC: state_nxt = F_DEC;
      F_DEC: begin
        state_nxt = F_IDLE;
        if (item_r.req_type == REQ_PIXEL) begin
          q_push       = 1'b1;
          q_cmd.wr     = 1'b1;
          q_cmd.emit   = (pend > (POS_BITS+1)'(w));
          q_cmd.addr   = in_col_r;
          q_cmd.sample = item_r.raw_sample;
          {in_row_nxt, in_col_nxt} = in_adv;
          if (q_cmd.emit) {em_row_nxt, em_col_nxt} = em_adv;
        end else if (in_col_r == '0 && in_row_r == '0 && pend != '0) begin
          q_push     = 1'b1;
          q_cmd.emit = 1'b1;
          q_cmd.addr = vcol[ADDR_BITS-1:0];
          {em_row_nxt, em_col_nxt} = em_adv;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= F_IDLE;
      frame_width_r  <= WIDTH_RESET;
      frame_height_r <= HEIGHT_RESET;
      cfa_r          <= '0;
      in_col_r       <= '0;
      in_row_r       <= '0;
      em_col_r       <= '0;
      em_row_r       <= '0;
    end else begin
      state_r  <= state_nxt;
      in_col_r <= in_col_nxt;
      in_row_r <= in_row_nxt;
      em_col_r <= em_col_nxt;
      em_row_r <= em_row_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_FRAME_WIDTH:  frame_width_r  <= cfg_data;
          REG_FRAME_HEIGHT: frame_height_r <= cfg_data;
          REG_CFA_PATTERN:  cfa_r          <= cfg_data[1:0];
          default: ;
        endcase
      end
    end
  end

  // linear positions for the pending-distance check
  always_ff @(posedge clk) begin
    if (accept) item_r <= in_data;
    if (state_r == F_CALC) begin
      pa_r    <= POS_BITS'(in_row_r) * POS_BITS'(w) + POS_BITS'(in_col_r);
      pb_r    <= POS_BITS'(em_row_r) * POS_BITS'(w) + POS_BITS'(em_col_r);
      total_r <= POS_BITS'(w) * POS_BITS'(h);
    end
  end

endmodule

/* hdl/bbd_back.sv */
// ----------------------------------------------------------------------------
// bbd_back - window and interpolation side of the demosaic
// Pop commands, update line stores and window, average and emit pixels.
// ----------------------------------------------------------------------------
module bbd_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_empty,
  input  bbd_pkg::cmd_t                  q_head,
  output logic                           q_pop,
  output logic                           ram_we,
  output logic [bbd_pkg::ADDR_BITS-1:0]  ram_waddr,
  output logic [2*bbd_pkg::SAMPLE_BITS-1:0] ram_wdata,
  output logic                           ram_re,
  output logic [bbd_pkg::ADDR_BITS-1:0]  ram_raddr,
  input  logic [2*bbd_pkg::SAMPLE_BITS-1:0] ram_rdata,
  output logic                           out_valid,
  input  logic                           out_ready,
  output bbd_pkg::out_word_t             out_data
);
  import bbd_pkg::*;

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_RD   = 4'b0010,
    B_SUM  = 4'b0100,
    B_DIV  = 4'b1000
  } bstate_t;

  bstate_t                state_r, state_nxt;
  cmd_t                   cmd_r;
  logic [SAMPLE_BITS-1:0] win_r [9];
  logic [SUM_BITS-1:0]    num_r [3], num_nxt [3];
  logic [CNT_BITS-1:0]    cnt_r [3], cnt_nxt [3];
  out_word_t              out_r;
  logic                   out_valid_r;
  logic                   load;

  logic [SAMPLE_BITS-1:0] up, lo;
  logic [SUM_BITS-1:0]    c, cs, hs, vs;
  logic [CNT_BITS-1:0]    cc, hc, vc;
  logic                   border;

  assign {up, lo}  = ram_rdata;
  assign q_pop     = (state_r == B_IDLE) && !q_empty;
  assign ram_re    = q_pop;
  assign ram_raddr = q_head.addr;
  assign ram_we    = (state_r == B_RD) && cmd_r.wr;
  assign ram_waddr = cmd_r.addr;
  assign ram_wdata = {lo, cmd_r.sample};
  assign load      = (state_r == B_DIV) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    unique case (state_r)
      B_IDLE:  state_nxt = q_pop ? B_RD : B_IDLE;
      B_RD:    state_nxt = cmd_r.emit ? B_SUM : B_IDLE;
      B_SUM:   state_nxt = B_DIV;
      B_DIV:   state_nxt = load ? B_IDLE : B_DIV;
      default: state_nxt = B_IDLE;
    endcase
  end

  // neighbor sums over the existing neighbors only
  always_comb begin
    c  = SUM_BITS'(win_r[4]);
    cs = '0; cc = '0; hs = '0; hc = '0; vs = '0; vc = '0;
    if (cmd_r.has_u && cmd_r.has_l) begin cs = cs + SUM_BITS'(win_r[0]); cc = cc + 3'd1; end
    if (cmd_r.has_u && cmd_r.has_r) begin cs = cs + SUM_BITS'(win_r[2]); cc = cc + 3'd1; end
    if (cmd_r.has_d && cmd_r.has_l) begin cs = cs + SUM_BITS'(win_r[6]); cc = cc + 3'd1; end
    if (cmd_r.has_d && cmd_r.has_r) begin cs = cs + SUM_BITS'(win_r[8]); cc = cc + 3'd1; end
    if (cmd_r.has_l) begin hs = hs + SUM_BITS'(win_r[3]); hc = hc + 3'd1; end
    if (cmd_r.has_r) begin hs = hs + SUM_BITS'(win_r[5]); hc = hc + 3'd1; end
    if (cmd_r.has_u) begin vs = vs + SUM_BITS'(win_r[1]); vc = vc + 3'd1; end
    if (cmd_r.has_d) begin vs = vs + SUM_BITS'(win_r[7]); vc = vc + 3'd1; end
    border = !cmd_r.has_l || !cmd_r.has_r || !cmd_r.has_u || !cmd_r.has_d;

    // index 0 blue, 1 green, 2 red
    unique case (cmd_r.site)
      SITE_GREEN_R, SITE_GREEN_B: begin
        num_nxt[1] = border ? c + cs : c;
        cnt_nxt[1] = border ? cc + 3'd1 : 3'd1;
        if (cmd_r.site == SITE_GREEN_R) begin
          num_nxt[0] = vs; cnt_nxt[0] = vc;
          num_nxt[2] = hs; cnt_nxt[2] = hc;
        end else begin
          num_nxt[0] = hs; cnt_nxt[0] = hc;
          num_nxt[2] = vs; cnt_nxt[2] = vc;
        end
      end
      SITE_RED: begin
        num_nxt[1] = hs + vs; cnt_nxt[1] = hc + vc;
        num_nxt[0] = cs;      cnt_nxt[0] = cc;
        num_nxt[2] = c;       cnt_nxt[2] = 3'd1;
      end
      default: begin
        num_nxt[1] = hs + vs; cnt_nxt[1] = hc + vc;
        num_nxt[0] = c;       cnt_nxt[0] = 3'd1;
        num_nxt[2] = cs;      cnt_nxt[2] = cc;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 9; i++) win_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      if (load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      // shift the window left by one column
      if (state_r == B_RD) begin
        win_r[0] <= win_r[1]; win_r[1] <= win_r[2]; win_r[2] <= up;
        win_r[3] <= win_r[4]; win_r[4] <= win_r[5]; win_r[5] <= lo;
        win_r[6] <= win_r[7]; win_r[7] <= win_r[8]; win_r[8] <= cmd_r.sample;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cmd_r <= q_head;
    if (state_r == B_SUM) begin
      for (int i = 0; i < 3; i++) begin
        num_r[i] <= num_nxt[i];
        cnt_r[i] <= cnt_nxt[i];
      end
    end
    if (load) begin
      out_r.blue_value  <= div_count(num_r[0], cnt_r[0]);
      out_r.green_value <= div_count(num_r[1], cnt_r[1]);
      out_r.red_value   <= div_count(num_r[2], cnt_r[2]);
      out_r.out_column  <= cmd_r.x;
      out_r.out_row     <= cmd_r.y;
      out_r.frame_end   <= cmd_r.last;
    end
  end

endmodule

/* hdl/bilinear_bayer_demosaic_top.sv */
// ----------------------------------------------------------------------------
// bilinear_bayer_demosaic_top - streaming bilinear Bayer demosaic
// Raw Bayer words in, blue/green/red pixels with position out.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one word per raw sample in raster order (req_type pixel), or a
//           flush word that drains one pending pixel once a frame is complete.
//   out_* : one word per pixel: blue, green, red, column, row, frame_end.
//   cfg_* : write frame_width, frame_height or cfa_pattern while idle.
// Flow:
//   The front end handles one input word at a time (accept, position
//   multiply, decision). The back end gives a word with no pixel a line
//   store read and a window shift, and a word that emits one also neighbor
//   sums and a divide; neither end takes a new word before it is through
//   with the last one. A pixel comes out with the word taken frame_width + 1
//   raw words after its sample; out_valid rises once that word has passed
//   these steps and the queue, when the back end is free.
// Reset: counters, window, registers clear (640 x 480, pattern 0 = GBRG);
//   line store contents are unknown until written and need no clearing pass.
// Stall: when out_ready is low the result holds in the output register; the
//   front keeps accepting words until the four-entry queue fills.
// ----------------------------------------------------------------------------
module bilinear_bayer_demosaic_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  bbd_pkg::in_word_t            in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output bbd_pkg::out_word_t           out_data,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [bbd_pkg::DIM_BITS-1:0] cfg_data
);
  import bbd_pkg::*;

  cmd_t                       push_cmd, head_cmd;
  logic                       q_push, q_pop, q_full, q_empty;
  logic                       ram_we, ram_re;
  logic [ADDR_BITS-1:0]       ram_waddr, ram_raddr;
  logic [2*SAMPLE_BITS-1:0]   ram_wdata, ram_rdata;

  // front: positions, pending distance, command decode
  bbd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  // queue decouples decode from window processing
  bbd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  // both line stores share one word: upper line high, lower line low
  bbd_ram #(
    .WIDTH (2*SAMPLE_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // back: window, averaging, output register
  bbd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (head_cmd),
    .q_pop     (q_pop),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
